FILE: hdl/adam_pkg.sv
// Shared types, constants and arithmetic step functions for the Adam element update block.
// Used by the top level and the moment store; depends on nothing else.
package adam_pkg;

    localparam int MOMENT_DEPTH = 4096;
    localparam int SLOT_W = (MOMENT_DEPTH > 1) ? $clog2(MOMENT_DEPTH) : 1;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    localparam logic [23:0] RST_LEARN_RATE   = 24'd16777;
    localparam logic [23:0] RST_WEIGHT_DECAY = 24'd0;
    localparam logic [23:0] RST_BETA_ONE     = 24'd15099494;
    localparam logic [23:0] RST_BETA_TWO     = 24'd16760439;
    localparam logic [23:0] RST_EPSILON      = 24'd1;

    localparam int V_STEPS = 64;
    localparam int S_STEPS = 32;
    localparam int R_STEPS = 62;

    typedef enum logic [2:0] {
        CFG_LEARN_RATE   = 3'd0,
        CFG_WEIGHT_DECAY = 3'd1,
        CFG_BETA_ONE     = 3'd2,
        CFG_BETA_TWO     = 3'd3,
        CFG_EPSILON      = 3'd4
    } t_cfg_index;

    // Write request into the moment store.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [31:0]       m;
        logic [63:0]       v;
    } t_mom_wr;

    // Per-item context that rides along the whole pipeline.
    typedef struct packed {
        logic [11:0]        idx;
        logic signed [31:0] w;
        logic               m_pos;
        logic               m_neg;
        logic               flag;
        logic               dz;
    } t_ctx;

    function automatic logic [SLOT_W-1:0] slot_of(logic [11:0] idx);
        return SLOT_W'(32'(idx) % MOMENT_DEPTH);
    endfunction

    // One restoring division step: 24-bit remainder, 64 dividend/quotient bits.
    function automatic logic [87:0] div24_step(logic [87:0] rn, logic [24:0] d);
        logic [24:0] r2;
        logic [24:0] diff;
        logic        ge;
        r2   = {rn[87:64], rn[63]};
        ge   = (r2 >= d);
        diff = r2 - d;
        return {(ge ? diff[23:0] : r2[23:0]), rn[62:0], ge};
    endfunction

    // One restoring division step: 33-bit remainder, 62 dividend/quotient bits.
    function automatic logic [94:0] div33_step(logic [94:0] rn, logic [32:0] d);
        logic [33:0] r2;
        logic [33:0] diff;
        logic        ge;
        r2   = {rn[94:62], rn[61]};
        ge   = (r2 >= {1'b0, d});
        diff = r2 - {1'b0, d};
        return {(ge ? diff[32:0] : r2[32:0]), rn[60:0], ge};
    endfunction

    // One digit of the integer square root. State is {x[63:0], rem[32:0], res[31:0]}.
    function automatic logic [128:0] sqrt_step(logic [128:0] st);
        logic [63:0] x;
        logic [32:0] rem;
        logic [31:0] res;
        logic [34:0] rem2;
        logic [34:0] trial;
        logic [34:0] diff;
        logic        ge;
        x     = st[128:65];
        rem   = st[64:32];
        res   = st[31:0];
        rem2  = {rem, x[63:62]};
        trial = {1'b0, res, 2'b01};
        ge    = (rem2 >= trial);
        diff  = rem2 - trial;
        return {x[61:0], 2'b00, (ge ? diff[32:0] : rem2[32:0]), res[30:0], ge};
    endfunction

endpackage

FILE: hdl/adam_moment_ram.sv
// Moment store: first and second moments per element slot, one read and one write port.
// Runs a clearing pass after reset. Depends on adam_pkg.
module adam_moment_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [adam_pkg::SLOT_W-1:0] i_rd_addr,
    output logic [31:0]                 o_rd_m,
    output logic [63:0]                 o_rd_v,
    input  adam_pkg::t_mom_wr           i_wr,
    output logic                        o_clearing
);

    logic [95:0]                 r_mem [adam_pkg::MOMENT_DEPTH];
    logic [95:0]                 r_rd;
    logic [adam_pkg::SLOT_W-1:0] r_clr_cnt;
    logic                        r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == adam_pkg::SLOT_W'(adam_pkg::MOMENT_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= {i_wr.m, i_wr.v};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_m     = r_rd[95:64];
    assign o_rd_v     = r_rd[63:0];
    assign o_clearing = r_clearing;

endmodule

FILE: hdl/adam_optimizer_element_update.sv
// Takes one element per cycle unless the output stalls or the moment store is cleared.
// The depth is set by the bit-serial pipelines: 64 stages of bias-correction division,
// 32 stages of square root and 62 stages of ratio division, all one bit or digit a stage.
// A stall on the output freezes the whole pipeline together with the output register.
// Reset (synchronous, active low) restores registers and beta powers and then clears the
// moment store, during which no input transfer is taken.
module adam_optimizer_element_update (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [11:0]        i_elem_index,
    input  logic signed [31:0] i_weight_in,
    input  logic signed [31:0] i_gradient,
    input  logic               i_decay_on,
    input  logic               i_step_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_elem_index_out,
    output logic signed [31:0] o_weight_out,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int VS = adam_pkg::V_STEPS;
    localparam int SS = adam_pkg::S_STEPS;
    localparam int RS = adam_pkg::R_STEPS;

    // Configuration registers and beta powers.
    logic [23:0] r_learn_rate, r_weight_decay, r_beta_one, r_beta_two, r_epsilon;
    logic [24:0] r_pow1, r_pow2;

    // Every stage moves when the output register is free or is being drained.
    logic w_adv, w_accept, w_clearing;
    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv || w_clearing;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learn_rate   <= adam_pkg::RST_LEARN_RATE;
            r_weight_decay <= adam_pkg::RST_WEIGHT_DECAY;
            r_beta_one     <= adam_pkg::RST_BETA_ONE;
            r_beta_two     <= adam_pkg::RST_BETA_TWO;
            r_epsilon      <= adam_pkg::RST_EPSILON;
        end else if (i_cfg_valid) begin
            unique case (adam_pkg::t_cfg_index'(i_cfg_index))
                adam_pkg::CFG_LEARN_RATE:   r_learn_rate   <= i_cfg_data;
                adam_pkg::CFG_WEIGHT_DECAY: r_weight_decay <= i_cfg_data;
                adam_pkg::CFG_BETA_ONE:     r_beta_one     <= i_cfg_data;
                adam_pkg::CFG_BETA_TWO:     r_beta_two     <= i_cfg_data;
                adam_pkg::CFG_EPSILON:      r_epsilon      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A step start advances the beta powers before this element uses them, so the
    // correction denominators are taken from the updated values.
    logic [48:0] w_pp1, w_pp2;
    logic [24:0] n_pow1, n_pow2;
    assign w_pp1  = r_pow1 * r_beta_one;
    assign w_pp2  = r_pow2 * r_beta_two;
    assign n_pow1 = i_step_start ? w_pp1[48:24] : r_pow1;
    assign n_pow2 = i_step_start ? w_pp2[48:24] : r_pow2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pow1 <= adam_pkg::ONE_Q24;
            r_pow2 <= adam_pkg::ONE_Q24;
        end else if (w_accept) begin
            r_pow1 <= n_pow1;
            r_pow2 <= n_pow2;
        end
    end

    // Stage 1: captured input.
    logic               r1_valid;
    adam_pkg::t_ctx     r1_ctx;
    logic signed [31:0] r1_g;
    logic               r1_decay;
    logic [24:0]        r1_d1, r1_d2;

    // Stage 2: decay product.
    logic               r2_valid;
    adam_pkg::t_ctx     r2_ctx;
    logic signed [31:0] r2_g;
    logic signed [56:0] r2_prod;
    logic [24:0]        r2_d1, r2_d2;

    // Stage 3: decayed gradient.
    logic               r3_valid;
    adam_pkg::t_ctx     r3_ctx;
    logic signed [31:0] r3_gi;
    logic [24:0]        r3_d1, r3_d2;

    // Stage 4: gradient square and first moment input term.
    logic               r4_valid;
    adam_pkg::t_ctx     r4_ctx;
    logic [63:0]        r4_sq;
    logic signed [57:0] r4_pm;
    logic [24:0]        r4_d1, r4_d2;

    // Stage 5: split products of the second moment input term.
    logic               r5_valid;
    adam_pkg::t_ctx     r5_ctx;
    logic [63:0]        r5_pv_hi;
    logic [48:0]        r5_pv_lo;
    logic signed [57:0] r5_pm;
    logic [24:0]        r5_d1, r5_d2;

    // Stage 6: moment read data arrives; read-modify-write of the moments.
    logic               r6_valid;
    adam_pkg::t_ctx     r6_ctx;
    logic [63:0]        r6_pre_v;
    logic signed [57:0] r6_pm;
    logic [24:0]        r6_d1, r6_d2;
    logic               r6_fwd;

    // Stage 7: updated moments.
    logic               r7_valid;
    adam_pkg::t_ctx     r7_ctx;
    logic signed [31:0] r7_m;
    logic [63:0]        r7_v;
    logic [24:0]        r7_d1, r7_d2;

    logic signed [56:0] w_dprod;
    logic signed [33:0] w_gi_wide;
    logic signed [31:0] w_gi;
    logic               w_gi_sat;
    logic signed [63:0] w_sq;
    logic signed [57:0] w_pm;
    logic [24:0]        w_ob1, w_ob2;
    logic [64:0]        w_pv_hi;

    assign w_dprod   = $signed({1'b0, r_weight_decay}) * r1_ctx.w;
    assign w_ob1     = adam_pkg::ONE_Q24 - 25'(r_beta_one);
    assign w_ob2     = adam_pkg::ONE_Q24 - 25'(r_beta_two);

    // The decay term is floor(product / 2^24), so its top bits are kept signed.
    always_comb begin
        w_gi_wide = 34'(r2_g) + 34'($signed(r2_prod[56:24]));
        w_gi_sat  = 1'b0;
        if (w_gi_wide > 34'sd2147483647) begin
            w_gi     = 32'sh7FFF_FFFF;
            w_gi_sat = 1'b1;
        end else if (w_gi_wide < -34'sd2147483648) begin
            w_gi     = 32'sh8000_0000;
            w_gi_sat = 1'b1;
        end else begin
            w_gi = w_gi_wide[31:0];
        end
    end

    assign w_sq    = r3_gi * r3_gi;
    assign w_pm    = $signed({1'b0, w_ob1}) * r3_gi;
    assign w_pv_hi = w_ob2 * r4_sq[63:24];

    // Moment store.
    logic [31:0]       w_rd_m;
    logic [63:0]       w_rd_v;
    adam_pkg::t_mom_wr w_wr;

    adam_moment_ram u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_adv),
        .i_rd_addr  (adam_pkg::slot_of(r5_ctx.idx)),
        .o_rd_m     (w_rd_m),
        .o_rd_v     (w_rd_v),
        .i_wr       (w_wr),
        .o_clearing (w_clearing)
    );

    // The only write that can land between the read and its use is the one made by
    // the element just ahead, which is then taken from stage 7 instead.
    logic signed [31:0] w_old_m;
    logic [63:0]        w_old_v;
    logic signed [58:0] w_m_sum;
    logic signed [31:0] n_m;
    logic [63:0]        w_v_hi;
    logic [47:0]        w_v_lo;
    logic [63:0]        n_v;

    assign w_old_m = r6_fwd ? r7_m : $signed(w_rd_m);
    assign w_old_v = r6_fwd ? r7_v : w_rd_v;
    assign w_m_sum = 59'($signed({1'b0, r_beta_one}) * w_old_m) + 59'(r6_pm);
    assign n_m     = w_m_sum[55:24];
    assign w_v_hi  = r_beta_two * w_old_v[63:24];
    assign w_v_lo  = r_beta_two * w_old_v[23:0];
    assign n_v     = w_v_hi + 64'(w_v_lo[47:24]) + r6_pre_v;

    always_comb begin
        w_wr.en   = r6_valid && w_adv;
        w_wr.addr = adam_pkg::slot_of(r6_ctx.idx);
        w_wr.m    = n_m;
        w_wr.v    = n_v;
    end

    // Context of stages 3 and 7 with the fields that those stages settle.
    adam_pkg::t_ctx n_r3_ctx, n_r7_ctx;

    always_comb begin
        n_r3_ctx       = r2_ctx;
        n_r3_ctx.flag  = r2_ctx.flag | w_gi_sat;
        n_r7_ctx       = r6_ctx;
        n_r7_ctx.m_pos = (n_m > 32'sd0);
        n_r7_ctx.m_neg = n_m[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ctx.idx   <= i_elem_index;
            r1_ctx.w     <= i_weight_in;
            r1_ctx.m_pos <= 1'b0;
            r1_ctx.m_neg <= 1'b0;
            r1_ctx.flag  <= 1'b0;
            r1_ctx.dz    <= 1'b0;
            r1_g         <= i_gradient;
            r1_decay     <= i_decay_on;
            r1_d1        <= adam_pkg::ONE_Q24 - n_pow1;
            r1_d2        <= adam_pkg::ONE_Q24 - n_pow2;

            r2_ctx  <= r1_ctx;
            r2_g    <= r1_g;
            r2_prod <= r1_decay ? w_dprod : '0;
            r2_d1   <= r1_d1;
            r2_d2   <= r1_d2;

            r3_ctx      <= n_r3_ctx;
            r3_gi       <= w_gi;
            r3_d1       <= r2_d1;
            r3_d2       <= r2_d2;

            r4_ctx <= r3_ctx;
            r4_sq  <= w_sq;
            r4_pm  <= w_pm;
            r4_d1  <= r3_d1;
            r4_d2  <= r3_d2;

            r5_ctx   <= r4_ctx;
            r5_pv_hi <= w_pv_hi[63:0];
            r5_pv_lo <= w_ob2 * r4_sq[23:0];
            r5_pm    <= r4_pm;
            r5_d1    <= r4_d1;
            r5_d2    <= r4_d2;

            r6_ctx   <= r5_ctx;
            r6_pre_v <= r5_pv_hi + 64'(r5_pv_lo[48:24]);
            r6_pm    <= r5_pm;
            r6_d1    <= r5_d1;
            r6_d2    <= r5_d2;
            r6_fwd   <= r6_valid &&
                        (adam_pkg::slot_of(r6_ctx.idx) == adam_pkg::slot_of(r5_ctx.idx));

            r7_ctx       <= n_r7_ctx;
            r7_m         <= n_m;
            r7_v         <= n_v;
            r7_d1        <= r6_d1;
            r7_d2        <= r6_d2;
        end
    end

    // Bias correction: vhat = v * 2^24 / d2 and mhat = |m| * 2^24 / d1, side by side.
    // An overflowing vhat is caught up front by one compare of v against d2 * 2^40.
    logic           r_v_valid [VS+1];
    adam_pkg::t_ctx r_v_ctx   [VS+1];
    logic [87:0]    r_v_rn    [VS+1];
    logic [87:0]    r_m_rn    [VS+1];
    logic [24:0]    r_v_d1    [VS+1];
    logic [24:0]    r_v_d2    [VS+1];
    logic           r_v_ov    [VS+1];

    logic        w_v_ov;
    logic [31:0] w_mmag;
    assign w_v_ov = ({1'b0, r7_v} >= {r7_d2, 40'd0});
    assign w_mmag = r7_m[31] ? 32'(-r7_m) : 32'(r7_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_v_valid[0] <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_v_ctx[0] <= r7_ctx;
            r_v_rn[0]  <= {(w_v_ov ? 24'd0 : r7_v[63:40]), r7_v[39:0], 24'd0};
            r_m_rn[0]  <= {24'd0, 8'd0, w_mmag, 24'd0};
            r_v_d1[0]  <= r7_d1;
            r_v_d2[0]  <= r7_d2;
            r_v_ov[0]  <= w_v_ov;
        end
    end

    for (genvar k = 0; k < VS; k++) begin : g_vdiv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v_valid[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_v_valid[k+1] <= r_v_valid[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_v_ctx[k+1] <= r_v_ctx[k];
                r_v_rn[k+1]  <= adam_pkg::div24_step(r_v_rn[k], r_v_d2[k]);
                r_m_rn[k+1]  <= adam_pkg::div24_step(r_m_rn[k], r_v_d1[k]);
                r_v_d1[k+1]  <= r_v_d1[k];
                r_v_d2[k+1]  <= r_v_d2[k];
                r_v_ov[k+1]  <= r_v_ov[k];
            end
        end
    end

    // Square root of vhat, two radicand bits a stage. A zero d1 or d2 marks the
    // element for the zero denominator result.
    logic           r_s_valid [SS+1];
    adam_pkg::t_ctx r_s_ctx   [SS+1];
    logic [128:0]   r_s_st    [SS+1];
    logic [63:0]    r_s_mhat  [SS+1];
    adam_pkg::t_ctx n_s_ctx;

    always_comb begin
        n_s_ctx      = r_v_ctx[VS];
        n_s_ctx.dz   = (r_v_d1[VS] == '0) || (r_v_d2[VS] == '0);
        n_s_ctx.flag = r_v_ctx[VS].flag | r_v_ov[VS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_s_valid[0] <= r_v_valid[VS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s_ctx[0]      <= n_s_ctx;
            r_s_st[0]       <= {(r_v_ov[VS] ? 64'hFFFF_FFFF_FFFF_FFFF : r_v_rn[VS][63:0]),
                                33'd0, 32'd0};
            r_s_mhat[0]     <= r_m_rn[VS][63:0];
        end
    end

    for (genvar k = 0; k < SS; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_s_valid[k+1] <= r_s_valid[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_s_ctx[k+1]  <= r_s_ctx[k];
                r_s_st[k+1]   <= adam_pkg::sqrt_step(r_s_st[k]);
                r_s_mhat[k+1] <= r_s_mhat[k];
            end
        end
    end

    // Denominator: root plus epsilon. Only a zero root with a zero epsilon gives zero.
    logic           r_dn_valid;
    adam_pkg::t_ctx r_dn_ctx;
    logic [32:0]    r_dn_den;
    logic [63:0]    r_dn_mhat;
    logic [32:0]    w_den;
    adam_pkg::t_ctx n_dn_ctx;
    assign w_den = {1'b0, r_s_st[SS][31:0]} + 33'(r_epsilon);

    always_comb begin
        n_dn_ctx    = r_s_ctx[SS];
        n_dn_ctx.dz = r_s_ctx[SS].dz || (w_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_valid <= 1'b0;
        end else if (w_adv) begin
            r_dn_valid <= r_s_valid[SS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dn_ctx    <= n_dn_ctx;
            r_dn_den    <= w_den;
            r_dn_mhat   <= r_s_mhat[SS];
        end
    end

    // Ratio mhat * 2^24 / den. It is capped at 2^62 when mhat reaches den * 2^38.
    logic           r_r_valid [RS+1];
    adam_pkg::t_ctx r_r_ctx   [RS+1];
    logic [94:0]    r_r_rn    [RS+1];
    logic [32:0]    r_r_den   [RS+1];
    logic           r_r_ov    [RS+1];
    logic           w_r_ov;
    assign w_r_ov = ({7'd0, r_dn_mhat} >= {r_dn_den, 38'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_r_valid[0] <= r_dn_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_r_ctx[0] <= r_dn_ctx;
            r_r_rn[0]  <= {(w_r_ov ? 33'd0 : 33'(r_dn_mhat[63:38])),
                           r_dn_mhat[37:0], 24'd0};
            r_r_den[0] <= r_dn_den;
            r_r_ov[0]  <= w_r_ov;
        end
    end

    for (genvar k = 0; k < RS; k++) begin : g_rdiv
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_r_valid[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_r_valid[k+1] <= r_r_valid[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_r_ctx[k+1] <= r_r_ctx[k];
                r_r_rn[k+1]  <= adam_pkg::div33_step(r_r_rn[k], r_r_den[k]);
                r_r_den[k+1] <= r_r_den[k];
                r_r_ov[k+1]  <= r_r_ov[k];
            end
        end
    end

    // Step size: learn_rate times ratio, split into two partial products.
    logic           r_t1_valid;
    adam_pkg::t_ctx r_t1_ctx;
    logic [62:0]    r_t1_hi;
    logic [47:0]    r_t1_lo;
    logic [62:0]    w_ratio;
    adam_pkg::t_ctx n_t1_ctx;
    assign w_ratio = r_r_ov[RS] ? {1'b1, 62'd0} : {1'b0, r_r_rn[RS][61:0]};

    always_comb begin
        n_t1_ctx      = r_r_ctx[RS];
        n_t1_ctx.flag = r_r_ctx[RS].flag | (r_r_ov[RS] && !r_r_ctx[RS].dz);
    end

    logic           r_t2_valid;
    adam_pkg::t_ctx r_t2_ctx;
    logic signed [64:0] r_t2_res;
    logic [62:0]    w_step;
    assign w_step = r_t1_hi + 63'(r_t1_lo[47:24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
            r_t2_valid <= 1'b0;
        end else if (w_adv) begin
            r_t1_valid <= r_r_valid[RS];
            r_t2_valid <= r_t1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1_ctx      <= n_t1_ctx;
            r_t1_hi       <= r_learn_rate * w_ratio[62:24];
            r_t1_lo       <= r_learn_rate * w_ratio[23:0];

            r_t2_ctx <= r_t1_ctx;
            r_t2_res <= r_t1_ctx.m_pos ? (65'(r_t1_ctx.w) - $signed({2'b00, w_step}))
                                       : (65'(r_t1_ctx.w) + $signed({2'b00, w_step}));
        end
    end

    // Output register: saturation, or the fixed result of a zero denominator.
    logic               r_out_valid;
    logic [11:0]        r_out_idx;
    logic signed [31:0] r_out_weight;
    logic               r_out_sat;
    logic signed [31:0] n_weight;
    logic               n_sat;

    always_comb begin
        n_sat = r_t2_ctx.flag;
        if (r_t2_ctx.dz) begin
            n_sat = 1'b1;
            if (r_t2_ctx.m_pos) begin
                n_weight = 32'sh8000_0000;
            end else if (r_t2_ctx.m_neg) begin
                n_weight = 32'sh7FFF_FFFF;
            end else begin
                n_weight = r_t2_ctx.w;
            end
        end else if (r_t2_res > 65'sd2147483647) begin
            n_weight = 32'sh7FFF_FFFF;
            n_sat    = 1'b1;
        end else if (r_t2_res < -65'sd2147483648) begin
            n_weight = 32'sh8000_0000;
            n_sat    = 1'b1;
        end else begin
            n_weight = r_t2_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_t2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_idx    <= r_t2_ctx.idx;
            r_out_weight <= n_weight;
            r_out_sat    <= n_sat;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_elem_index_out = r_out_idx;
    assign o_weight_out     = r_out_weight;
    assign o_saturated      = r_out_sat;

endmodule

FILE: hdl/adam_checker.sv
// Port-level checks for the Adam element update block, bound to its top level.
// Depends on the top level's port list only.
module adam_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [11:0]        o_elem_index_out,
    input logic signed [31:0] o_weight_out,
    input logic               o_saturated
);

    // A result held back by the sink must stay put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_weight_out)
            && $stable(o_elem_index_out) && $stable(o_saturated))
        else $error("output result changed while stalled");

    // The moment store is being cleared right after reset, so nothing is taken.
    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken while the moment store is cleared");

    // A frozen pipeline cannot take a new element.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while the output is stalled");

endmodule

bind adam_optimizer_element_update adam_checker u_adam_checker (.*);
